### design/hrpv_pkg.sv
package hrpv_pkg;

    // input request: one raw byte of the request text
    typedef struct packed {
        logic [7:0] request_byte;
        logic       first_of_request;
    } request_t;

    // result item as seen on the output queue
    typedef struct packed {
        logic       item_kind;
        logic [7:0] path_byte;
        logic [2:0] verdict;
        logic       file_included;
        logic [8:0] path_length;
        logic       last_of_run;
    } result_t;

    // command from the parser to the emitter: an optional path byte,
    // then an optional verdict
    typedef struct packed {
        logic       has_byte;
        logic [7:0] path_byte;
        logic       has_verdict;
        logic [2:0] verdict;
        logic       file_included;
        logic [8:0] path_length;
    } cmd_t;

    localparam int PATH_LEN_W = 9;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_METHOD_WORD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_METHOD_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTENSION_WORD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTENSION_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POLICY_FLAGS = 3'd4;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // verdict codes
    localparam logic [2:0] VERDICT_OK = 3'd0;
    localparam logic [2:0] VERDICT_METHOD = 3'd1;
    localparam logic [2:0] VERDICT_DOUBLE_DOT = 3'd2;
    localparam logic [2:0] VERDICT_HIDDEN = 3'd3;
    localparam logic [2:0] VERDICT_EXTENSION = 3'd4;
    localparam logic [2:0] VERDICT_TOO_LONG = 3'd5;

    // policy flag bits
    localparam int FLAG_CHECK_METHOD = 0;
    localparam int FLAG_ALLOW_DOUBLE_DOT = 1;
    localparam int FLAG_ALLOW_HIDDEN = 2;
    localparam int FLAG_CHECK_EXTENSION = 3;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_DOT = 8'h2e;

    localparam logic [3:0] WORD_CHARS = 4'd8;
    localparam logic [3:0] INDEX_MAX = 4'd15;

endpackage

### design/hrpv_front.sv
module hrpv_front #(
    parameter int MAX_PATH = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  hrpv_pkg::request_t                   request,
    input  logic                                 cfg_write,
    input  logic [hrpv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hrpv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 q_full,
    output logic                                 q_push,
    output hrpv_pkg::cmd_t                       q_cmd
);

    localparam int CNT_W = $clog2(MAX_PATH + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PATH);

    typedef enum logic [1:0] {
        PH_METHOD,
        PH_PATH,
        PH_DONE
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       m_idx_reg, m_idx_next;
    logic             m_match_reg, m_match_next;
    logic [7:0]       prev_reg, prev_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             file_reg, file_next;
    logic [3:0]       e_idx_reg, e_idx_next;
    logic             e_match_reg, e_match_next;

    logic [63:0]      method_word_reg;
    logic [3:0]       method_length_reg;
    logic [63:0]      ext_word_reg;
    logic [3:0]       ext_length_reg;
    logic [3:0]       flags_reg;

    logic             accept;
    logic             cmd_valid;
    hrpv_pkg::cmd_t   cmd;
    logic [7:0]       c;
    logic             ext_ok;

    function automatic logic [7:0] word_byte(input logic [63:0] w, input logic [2:0] i);
        word_byte = w[{i, 3'b000} +: 8];
    endfunction

    assign full = q_full;
    assign accept = push && !q_full;
    assign q_push = accept && cmd_valid;
    assign q_cmd = cmd;

    always_comb
    begin
        // a restart marker resets the parse before this byte
        if (request.first_of_request)
        begin
            phase_next = PH_METHOD;
            m_idx_next = '0;
            m_match_next = 1'b1;
            prev_next = '0;
            count_next = '0;
            file_next = 1'b0;
            e_idx_next = '0;
            e_match_next = 1'b1;
        end
        else
        begin
            phase_next = phase_reg;
            m_idx_next = m_idx_reg;
            m_match_next = m_match_reg;
            prev_next = prev_reg;
            count_next = count_reg;
            file_next = file_reg;
            e_idx_next = e_idx_reg;
            e_match_next = e_match_reg;
        end
        cmd = '0;
        cmd_valid = 1'b0;
        c = request.request_byte;
        ext_ok = !file_next || (e_match_next && e_idx_next == ext_length_reg);

        case (phase_next)
            PH_METHOD:
            begin
                if (c == hrpv_pkg::CH_SPACE)
                begin
                    cmd_valid = 1'b1;
                    if (flags_reg[hrpv_pkg::FLAG_CHECK_METHOD]
                        && !(m_match_next && m_idx_next == method_length_reg))
                    begin
                        cmd.has_verdict = 1'b1;
                        cmd.verdict = hrpv_pkg::VERDICT_METHOD;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_PATH;
                        count_next = CNT_W'(1);
                        cmd.has_byte = 1'b1;
                        cmd.path_byte = hrpv_pkg::CH_DOT;
                    end
                end
                else
                begin
                    if (m_idx_next >= hrpv_pkg::WORD_CHARS || m_idx_next >= method_length_reg
                        || word_byte(method_word_reg, m_idx_next[2:0]) != c)
                        m_match_next = 1'b0;
                    if (m_idx_next != hrpv_pkg::INDEX_MAX)
                        m_idx_next = m_idx_next + 4'd1;
                end
            end
            PH_PATH:
            begin
                cmd_valid = 1'b1;
                if (c == hrpv_pkg::CH_SPACE || c == hrpv_pkg::CH_NEWLINE
                    || c == hrpv_pkg::CH_NUL)
                begin
                    // end of path: extension, then length, then trailing slash
                    phase_next = PH_DONE;
                    cmd.has_verdict = 1'b1;
                    if (flags_reg[hrpv_pkg::FLAG_CHECK_EXTENSION] && !ext_ok)
                        cmd.verdict = hrpv_pkg::VERDICT_EXTENSION;
                    else if (prev_next != hrpv_pkg::CH_SLASH)
                    begin
                        if (count_next >= CNT_LIMIT)
                            cmd.verdict = hrpv_pkg::VERDICT_TOO_LONG;
                        else
                        begin
                            count_next = count_next + CNT_W'(1);
                            cmd.has_byte = 1'b1;
                            cmd.path_byte = hrpv_pkg::CH_SLASH;
                            cmd.verdict = hrpv_pkg::VERDICT_OK;
                            cmd.file_included = file_next;
                            cmd.path_length = hrpv_pkg::PATH_LEN_W'(count_next);
                        end
                    end
                    else
                    begin
                        cmd.verdict = hrpv_pkg::VERDICT_OK;
                        cmd.file_included = file_next;
                        cmd.path_length = hrpv_pkg::PATH_LEN_W'(count_next);
                    end
                end
                else
                begin
                    if (c == hrpv_pkg::CH_BACKSLASH)
                        c = hrpv_pkg::CH_SLASH;
                    if (!flags_reg[hrpv_pkg::FLAG_ALLOW_DOUBLE_DOT] && c == hrpv_pkg::CH_DOT
                        && prev_next == hrpv_pkg::CH_DOT)
                    begin
                        cmd.has_verdict = 1'b1;
                        cmd.verdict = hrpv_pkg::VERDICT_DOUBLE_DOT;
                        phase_next = PH_DONE;
                    end
                    else if (!flags_reg[hrpv_pkg::FLAG_ALLOW_HIDDEN] && c == hrpv_pkg::CH_DOT
                        && (prev_next == hrpv_pkg::CH_NUL || prev_next == hrpv_pkg::CH_SLASH))
                    begin
                        cmd.has_verdict = 1'b1;
                        cmd.verdict = hrpv_pkg::VERDICT_HIDDEN;
                        phase_next = PH_DONE;
                    end
                    else if (count_next >= CNT_LIMIT)
                    begin
                        cmd.has_verdict = 1'b1;
                        cmd.verdict = hrpv_pkg::VERDICT_TOO_LONG;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (c == hrpv_pkg::CH_SLASH)
                        begin
                            file_next = 1'b0;
                            e_idx_next = '0;
                            e_match_next = 1'b1;
                        end
                        else if (c == hrpv_pkg::CH_DOT && prev_next != hrpv_pkg::CH_DOT)
                        begin
                            file_next = 1'b1;
                            e_idx_next = '0;
                            e_match_next = 1'b1;
                        end
                        else if (file_next)
                        begin
                            if (e_idx_next >= hrpv_pkg::WORD_CHARS
                                || e_idx_next >= ext_length_reg
                                || word_byte(ext_word_reg, e_idx_next[2:0]) != c)
                                e_match_next = 1'b0;
                            if (e_idx_next != hrpv_pkg::INDEX_MAX)
                                e_idx_next = e_idx_next + 4'd1;
                        end
                        count_next = count_next + CNT_W'(1);
                        prev_next = c;
                        cmd.has_byte = 1'b1;
                        cmd.path_byte = c;
                    end
                end
            end
            default:
            begin
                // done: bytes dropped until the next restart
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            m_idx_reg <= '0;
            m_match_reg <= 1'b1;
            prev_reg <= '0;
            count_reg <= '0;
            file_reg <= 1'b0;
            e_idx_reg <= '0;
            e_match_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            m_idx_reg <= m_idx_next;
            m_match_reg <= m_match_next;
            prev_reg <= prev_next;
            count_reg <= count_next;
            file_reg <= file_next;
            e_idx_reg <= e_idx_next;
            e_match_reg <= e_match_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_word_reg <= '0;
            method_length_reg <= '0;
            ext_word_reg <= '0;
            ext_length_reg <= '0;
            flags_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hrpv_pkg::REG_METHOD_WORD: method_word_reg <= cfg_data;
                hrpv_pkg::REG_METHOD_LENGTH: method_length_reg <= cfg_data[3:0];
                hrpv_pkg::REG_EXTENSION_WORD: ext_word_reg <= cfg_data;
                hrpv_pkg::REG_EXTENSION_LENGTH: ext_length_reg <= cfg_data[3:0];
                hrpv_pkg::REG_POLICY_FLAGS: flags_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // the path count never runs past the limit
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_LIMIT)
        else $error("path count beyond limit");

    // a path byte is only queued from the path phase or its opening space
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push && cmd.has_byte |-> phase_reg != PH_DONE || request.first_of_request)
        else $error("path byte queued after verdict");

    // a finished request stays finished until a restart
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE && !(push && request.first_of_request) |=> phase_reg == PH_DONE)
        else $error("parse left done without restart");

endmodule

### design/hrpv_queue.sv
module hrpv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  hrpv_pkg::cmd_t wr_cmd,
    output logic           q_full,
    input  logic           rd,
    output logic           q_empty,
    output hrpv_pkg::cmd_t head
);

    localparam int PTR_W = $clog2(hrpv_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hrpv_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(hrpv_pkg::QUEUE_DEPTH);

    hrpv_pkg::cmd_t   slot_reg [hrpv_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign q_full = cnt_reg == DEPTH;
    assign q_empty = cnt_reg == '0;
    assign head = slot_reg[rp_reg];
    assign do_wr = wr && !q_full;
    assign do_rd = rd && !q_empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + PTR_W'(1);
            if (do_rd)
                rp_reg <= rp_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // occupancy tracks the pointer difference
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == DEPTH || PTR_W'(cnt_reg) == PTR_W'(wp_reg - rp_reg))
        else $error("queue count and pointers disagree");

endmodule

### design/hrpv_back.sv
module hrpv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  hrpv_pkg::cmd_t    head,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output hrpv_pkg::result_t result
);

    logic              out_valid_reg;
    hrpv_pkg::result_t out_reg;
    logic              byte_done_reg;
    logic              load;
    logic              emit_byte;
    hrpv_pkg::result_t item;

    assign empty = !out_valid_reg;
    assign result = out_reg;
    assign load = (!out_valid_reg || pop) && !q_empty;
    assign emit_byte = head.has_byte && !byte_done_reg;
    // retire the head once its last item goes out
    assign q_pop = load && !(emit_byte && head.has_verdict);

    always_comb
    begin
        item = '0;
        if (emit_byte)
        begin
            item.item_kind = hrpv_pkg::KIND_BYTE;
            item.path_byte = head.path_byte;
        end
        else
        begin
            item.item_kind = hrpv_pkg::KIND_VERDICT;
            item.verdict = head.verdict;
            item.file_included = head.file_included;
            item.path_length = head.path_length;
            item.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (load)
                byte_done_reg <= emit_byte && head.has_verdict;
        end
    end

    // a half-sent command keeps its place at the head of the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_done_reg |-> !q_empty && head.has_byte && head.has_verdict)
        else $error("split command lost its head entry");

    // only verdict items close a request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.last_of_run == out_reg.item_kind)
        else $error("last_of_run out of step with item kind");

    // the byte item of a split command is always followed by its verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        load && emit_byte && head.has_verdict |=> byte_done_reg)
        else $error("verdict of split command skipped");

endmodule

### design/http_request_path_validator.sv
// http request path validator: takes the raw bytes of a request one per cycle
// on a queue-style input (push/full), parses the method up to the first space,
// checks it against the configured word when enabled, then streams out the
// rewritten path (leading '.', backslash turned to '/', trailing '/' added)
// and closes each request with a verdict item (ok, method, double dot, hidden
// segment, extension, too long). path bytes go out before the verdict and are
// only meaningful when the verdict is ok. one byte is accepted every cycle as
// long as the four-entry command queue between the parser and the emitter has
// room; each byte yields at most one command, and the only command that gives
// two output items is a path end that adds the trailing '/'. the first result
// of an accepted byte passes through the command queue and then the output
// register, and can wait in the queue while the output stalls. the
// configuration registers are written through cfg_write/cfg_index/cfg_data
// and must only be changed while no request is in flight.
module http_request_path_validator #(
    parameter int MAX_PATH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request side
    input  logic                             push,
    output logic                             full,
    input  hrpv_pkg::request_t               request,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output hrpv_pkg::result_t                result,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [hrpv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hrpv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // parser to emitter command queue
    logic           q_push;
    hrpv_pkg::cmd_t q_cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    hrpv_pkg::cmd_t q_head;

    // front: method and path parsing, config registers, command generation
    hrpv_front #(
        .MAX_PATH(MAX_PATH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .request(request),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .q_full(q_full),
        .q_push(q_push),
        .q_cmd(q_cmd)
    );

    // short queue so the parser keeps taking bytes while results stall
    hrpv_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr(q_push),
        .wr_cmd(q_cmd),
        .q_full(q_full),
        .rd(q_pop),
        .q_empty(q_empty),
        .head(q_head)
    );

    // back: expands commands into result items behind an output register
    hrpv_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .head(q_head),
        .q_pop(q_pop),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int PATH_LIMIT = 256;
    // settle time after the last expected result: the output register, the
    // four-entry command queue and a possible trailing '/', with margin
    localparam int SETTLE_CYCLES = 12;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int BYTES_PER_PHASE = 60;
    localparam int MAX_PRINTED = 100;
    localparam logic [3:0] CHECK_BOTH =
        4'((1 << hrpv_pkg::FLAG_CHECK_METHOD) | (1 << hrpv_pkg::FLAG_CHECK_EXTENSION));

    // parser position for the predicted request
    typedef enum logic [1:0] {
        STAGE_METHOD,
        STAGE_PATH,
        STAGE_DONE
    } parse_stage_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic push = 1'b0;
    logic full;
    hrpv_pkg::request_t request = '0;

    // result side
    logic empty;
    logic pop = 1'b0;
    hrpv_pkg::result_t result;

    // configuration write port
    logic cfg_write = 1'b0;
    logic [hrpv_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [hrpv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // request bytes waiting for the driver, and the path bytes and verdicts
    // the block still owes us
    hrpv_pkg::request_t request_bytes_q[$];
    hrpv_pkg::result_t awaited_items[$];

    // shadow copy of the configuration registers
    logic [63:0] cfg_method_word = '0;
    logic [3:0] cfg_method_len = '0;
    logic [63:0] cfg_ext_word = '0;
    logic [3:0] cfg_ext_len = '0;
    logic [3:0] cfg_flags = '0;

    // predicted parser state
    parse_stage_t stage = STAGE_METHOD;
    int method_pos = 0;
    bit method_ok = 1'b1;
    logic [7:0] last_char = '0;
    int path_len = 0;
    bit file_open = 1'b0;
    int ext_pos = 0;
    bit ext_match = 1'b1;

    // bookkeeping
    int requests_queued = 0;
    int requests_accepted = 0;
    int mismatch_count = 0;
    int path_bytes_seen = 0;
    int verdicts_seen = 0;
    int verdict_tally[6] = '{default: 0};
    int settings_used = 0;
    int holds_done = 0;

    // idling state of both sides
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_cycle = 0;

    string method_names[6] = '{"GET", "POST", "HEAD", "DELETE", "OPTIONS", "PROPFIND"};
    string ext_names[5] = '{"html", "txt", "c", "tar", "markdown"};

    http_request_path_validator #(
        .MAX_PATH(PATH_LIMIT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    function automatic logic [63:0] pack_chars(string s);
        logic [63:0] w;
        int i;
        w = '0;
        for (i = 0; i < s.len() && i < 8; i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    task automatic await_path_byte(input logic [7:0] ch);
        hrpv_pkg::result_t r;
        r = '0;
        r.item_kind = hrpv_pkg::KIND_BYTE;
        r.path_byte = ch;
        awaited_items.push_back(r);
    endtask

    task automatic await_verdict(input logic [2:0] code, input bit with_file, input int len);
        hrpv_pkg::result_t r;
        r = '0;
        r.item_kind = hrpv_pkg::KIND_VERDICT;
        r.verdict = code;
        r.file_included = with_file;
        r.path_length = 9'(len);
        r.last_of_run = 1'b1;
        awaited_items.push_back(r);
    endtask

    // runs one accepted request byte through the path validation rules and
    // queues the path bytes and verdict it produces
    task automatic validate_request_byte(input hrpv_pkg::request_t rq);
        logic [7:0] ch;
        bit ext_ok;
        ch = rq.request_byte;

        // a marked first byte drops whatever request was in progress
        if (rq.first_of_request)
        begin
            stage = STAGE_METHOD;
            method_pos = 0;
            method_ok = 1'b1;
            last_char = hrpv_pkg::CH_NUL;
            path_len = 0;
            file_open = 1'b0;
            ext_pos = 0;
            ext_match = 1'b1;
        end

        case (stage)
            STAGE_METHOD:
            begin
                if (ch == hrpv_pkg::CH_SPACE)
                begin
                    if (cfg_flags[hrpv_pkg::FLAG_CHECK_METHOD] &&
                        !(method_ok && method_pos == int'(cfg_method_len)))
                    begin
                        await_verdict(hrpv_pkg::VERDICT_METHOD, 1'b0, 0);
                        stage = STAGE_DONE;
                    end
                    else
                    begin
                        stage = STAGE_PATH;
                        path_len = 1;
                        await_path_byte(hrpv_pkg::CH_DOT);
                    end
                end
                else
                begin
                    // past the eighth character nothing can match
                    if (method_pos >= 8 || method_pos >= int'(cfg_method_len) ||
                        cfg_method_word[8*(method_pos % 8) +: 8] != ch)
                        method_ok = 1'b0;
                    if (method_pos < 15)
                        method_pos++;
                end
            end
            STAGE_PATH:
            begin
                if (ch == hrpv_pkg::CH_SPACE || ch == hrpv_pkg::CH_NEWLINE ||
                    ch == hrpv_pkg::CH_NUL)
                begin
                    // end of path: extension first, then the trailing '/' limit
                    ext_ok = !file_open || (ext_match && ext_pos == int'(cfg_ext_len));
                    stage = STAGE_DONE;
                    if (cfg_flags[hrpv_pkg::FLAG_CHECK_EXTENSION] && !ext_ok)
                        await_verdict(hrpv_pkg::VERDICT_EXTENSION, 1'b0, 0);
                    else if (last_char != hrpv_pkg::CH_SLASH)
                    begin
                        if (path_len >= PATH_LIMIT)
                            await_verdict(hrpv_pkg::VERDICT_TOO_LONG, 1'b0, 0);
                        else
                        begin
                            path_len++;
                            await_path_byte(hrpv_pkg::CH_SLASH);
                            await_verdict(hrpv_pkg::VERDICT_OK, file_open, path_len);
                        end
                    end
                    else
                        await_verdict(hrpv_pkg::VERDICT_OK, file_open, path_len);
                end
                else
                begin
                    if (ch == hrpv_pkg::CH_BACKSLASH)
                        ch = hrpv_pkg::CH_SLASH;
                    if (!cfg_flags[hrpv_pkg::FLAG_ALLOW_DOUBLE_DOT] &&
                        ch == hrpv_pkg::CH_DOT && last_char == hrpv_pkg::CH_DOT)
                    begin
                        await_verdict(hrpv_pkg::VERDICT_DOUBLE_DOT, 1'b0, 0);
                        stage = STAGE_DONE;
                    end
                    else if (!cfg_flags[hrpv_pkg::FLAG_ALLOW_HIDDEN] &&
                             ch == hrpv_pkg::CH_DOT &&
                             (last_char == hrpv_pkg::CH_NUL ||
                              last_char == hrpv_pkg::CH_SLASH))
                    begin
                        await_verdict(hrpv_pkg::VERDICT_HIDDEN, 1'b0, 0);
                        stage = STAGE_DONE;
                    end
                    else if (path_len >= PATH_LIMIT)
                    begin
                        await_verdict(hrpv_pkg::VERDICT_TOO_LONG, 1'b0, 0);
                        stage = STAGE_DONE;
                    end
                    else
                    begin
                        if (ch == hrpv_pkg::CH_SLASH)
                        begin
                            file_open = 1'b0;
                            ext_pos = 0;
                            ext_match = 1'b1;
                        end
                        else if (ch == hrpv_pkg::CH_DOT && last_char != hrpv_pkg::CH_DOT)
                        begin
                            // a new dot restarts the extension
                            file_open = 1'b1;
                            ext_pos = 0;
                            ext_match = 1'b1;
                        end
                        else if (file_open)
                        begin
                            if (ext_pos >= 8 || ext_pos >= int'(cfg_ext_len) ||
                                cfg_ext_word[8*(ext_pos % 8) +: 8] != ch)
                                ext_match = 1'b0;
                            if (ext_pos < 15)
                                ext_pos++;
                        end
                        path_len++;
                        last_char = ch;
                        await_path_byte(ch);
                    end
                end
            end
            default:
                ; // verdict already given, bytes ignored until the next first byte
        endcase
    endtask

    // ---------------------------------------------------------------------
    // helpers for stimulus, idling and checking
    // ---------------------------------------------------------------------

    // mostly short gaps, a few long ones, none while in a steady stretch
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_byte(input logic [7:0] b, input bit first);
        hrpv_pkg::request_t rq;
        rq.request_byte = b;
        rq.first_of_request = first;
        request_bytes_q.push_back(rq);
        requests_queued++;
    endtask

    task automatic queue_line(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_byte(s[i], i == 0);
    endtask

    task automatic write_register(input logic [hrpv_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [hrpv_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            hrpv_pkg::REG_METHOD_WORD:      cfg_method_word = value;
            hrpv_pkg::REG_METHOD_LENGTH:    cfg_method_len = value[3:0];
            hrpv_pkg::REG_EXTENSION_WORD:   cfg_ext_word = value;
            hrpv_pkg::REG_EXTENSION_LENGTH: cfg_ext_len = value[3:0];
            hrpv_pkg::REG_POLICY_FLAGS:     cfg_flags = value[3:0];
            default:                        ;
        endcase
    endtask

    task automatic apply_policy(input logic [63:0] mword, input logic [3:0] mlen,
                                input logic [63:0] eword, input logic [3:0] elen,
                                input logic [3:0] flags);
        write_register(hrpv_pkg::REG_METHOD_WORD, mword);
        write_register(hrpv_pkg::REG_METHOD_LENGTH, 64'(mlen));
        write_register(hrpv_pkg::REG_EXTENSION_WORD, eword);
        write_register(hrpv_pkg::REG_EXTENSION_LENGTH, 64'(elen));
        write_register(hrpv_pkg::REG_POLICY_FLAGS, 64'(flags));
        settings_used++;
    endtask

    // idle means every queued byte taken and every awaited item seen, then a
    // settle wait for bytes that produce nothing
    task automatic wait_until_drained();
        while (requests_accepted != requests_queued || awaited_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // builds one request line; forced_len >= 0 gives a clean request with a
    // path of one '/' and then letters, exactly that many characters in all
    task automatic queue_random_request(input int forced_len);
        logic [7:0] text[$];
        logic [7:0] ch;
        int pick, len, base, i;
        bit tidy;

        pick = $urandom_range(0, 99);
        if (forced_len < 0 && pick < 8)
        begin
            // plain noise
            repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // method: mostly the configured one, else random or overlong
            if (forced_len >= 0 || pick < 75)
            begin
                for (i = 0; i < int'(cfg_method_len) && i < 8; i++)
                    text.push_back(cfg_method_word[8*i +: 8]);
            end
            else if (pick < 90)
                repeat ($urandom_range(0, 8)) text.push_back(8'($urandom_range(8'h41, 8'h5a)));
            else
                repeat ($urandom_range(9, 20)) text.push_back(8'($urandom_range(8'h41, 8'h5a)));
            // now and then the method never ends
            if (forced_len >= 0 || $urandom_range(0, 24) != 0)
                text.push_back(hrpv_pkg::CH_SPACE);

            tidy = forced_len >= 0 || $urandom_range(0, 99) < 75;
            if (forced_len >= 0)
                len = forced_len;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(0, 12);
            base = text.size();

            if (tidy)
            begin
                text.push_back(($urandom_range(0, 4) == 0 && forced_len < 0) ?
                               hrpv_pkg::CH_BACKSLASH : hrpv_pkg::CH_SLASH);
                while (text.size() - base < len)
                begin
                    pick = $urandom_range(0, 9);
                    if (forced_len < 0 && pick == 9 && text[$] != hrpv_pkg::CH_SLASH &&
                        text[$] != hrpv_pkg::CH_BACKSLASH && text[$] != hrpv_pkg::CH_DOT)
                    begin
                        // file name with the allowed extension, or a short other one
                        text.push_back(hrpv_pkg::CH_DOT);
                        if ($urandom_range(0, 2) != 0)
                        begin
                            for (i = 0; i < int'(cfg_ext_len) && i < 8; i++)
                                text.push_back(cfg_ext_word[8*i +: 8]);
                        end
                        else
                            repeat ($urandom_range(0, 3))
                                text.push_back(8'($urandom_range(8'h61, 8'h7a)));
                    end
                    else if (forced_len < 0 && pick == 8)
                        text.push_back(($urandom_range(0, 4) == 0) ?
                                       hrpv_pkg::CH_BACKSLASH : hrpv_pkg::CH_SLASH);
                    else
                        text.push_back(8'($urandom_range(8'h61, 8'h7a)));
                end
            end
            else
            begin
                // rough mix that trips the dot rules often
                repeat (len)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: ch = 8'($urandom_range(8'h61, 8'h7a));
                        4:          ch = hrpv_pkg::CH_SLASH;
                        5:          ch = hrpv_pkg::CH_BACKSLASH;
                        6, 7:       ch = hrpv_pkg::CH_DOT;
                        8:          ch = 8'($urandom_range(0, 255));
                        default:    ch = cfg_ext_word[8*$urandom_range(0, 7) +: 8];
                    endcase
                    text.push_back(ch);
                end
            end

            // terminator, sometimes missing so the next request cuts in
            pick = $urandom_range(0, 99);
            if (forced_len >= 0 || pick < 60)
                text.push_back(hrpv_pkg::CH_SPACE);
            else if (pick < 75)
                text.push_back(hrpv_pkg::CH_NEWLINE);
            else if (pick < 85)
                text.push_back(hrpv_pkg::CH_NUL);

            // a little trailing text the block should skip
            if (forced_len < 0 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
        end

        // rarely a first byte mark lands inside the line
        for (i = 0; i < text.size(); i++)
            queue_byte(text[i], i == 0 || $urandom_range(0, 99) == 0);
    endtask

    // ---------------------------------------------------------------------
    // request driver: offers queued bytes with random gaps
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                validate_request_byte(request);
                requests_accepted++;
                if ($urandom_range(0, 149) == 0)
                    send_steady = !send_steady;
                gap_left = pick_gap(send_steady);
            end
            // a refused request stays on the port unchanged
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (request_bytes_q.size() != 0)
                begin
                    request <= request_bytes_q.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // long receiver hold-offs, counted here so the block fills up and
    // pushes back on the driver; one early at a known cycle, others random
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_cycle <= 0;
        end
        else
        begin
            hold_cycle <= hold_cycle + 1;
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (hold_cycle == 400 || $urandom_range(0, 599) == 0)
            begin
                hold_left <= $urandom_range(40, 90);
                holds_done++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // result monitor: checks each popped item against the oldest one awaited
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        hrpv_pkg::result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (awaited_items.size() == 0)
                    report_mismatch("result with nothing awaited", result, 0);
                else
                begin
                    want = awaited_items.pop_front();
                    if (result.item_kind !== want.item_kind)
                        report_mismatch("item_kind", result.item_kind, want.item_kind);
                    if (result.path_byte !== want.path_byte)
                        report_mismatch("path_byte", result.path_byte, want.path_byte);
                    if (result.verdict !== want.verdict)
                        report_mismatch("verdict", result.verdict, want.verdict);
                    if (result.file_included !== want.file_included)
                        report_mismatch("file_included", result.file_included,
                                        want.file_included);
                    if (result.path_length !== want.path_length)
                        report_mismatch("path_length", result.path_length, want.path_length);
                    if (result.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", result.last_of_run, want.last_of_run);
                    if (want.item_kind == hrpv_pkg::KIND_VERDICT)
                    begin
                        verdicts_seen++;
                        if (want.verdict <= hrpv_pkg::VERDICT_TOO_LONG)
                            verdict_tally[want.verdict]++;
                    end
                    else
                        path_bytes_seen++;
                end
                if ($urandom_range(0, 149) == 0)
                    recv_steady = !recv_steady;
                stall_left = pick_gap(recv_steady);
            end
            else if (stall_left > 0)
                stall_left--;
            pop <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // ---------------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        logic [63:0] mword, eword;
        logic [3:0] mlen, elen;
        string name;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one-letter method and extension, both checks on
        apply_policy(pack_chars("G"), 4'd1, pack_chars("t"), 4'd1, CHECK_BOTH);
        queue_line("GE");          // dropped by the restart that follows
        queue_line("G /a.t ");     // file with the right extension, trailing '/'
        queue_line("X  ");         // wrong method, extra space ignored
        queue_line("G .");         // hidden segment right at the start
        queue_line("G a..");       // double dot
        queue_line("G a.b");       // wrong extension, ended by a zero byte
        queue_byte(hrpv_pkg::CH_NUL, 1'b0);
        queue_line("G \\ ");       // backslash becomes '/', nothing appended
        wait_until_drained();

        // random phases, each with its own register setting
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: apply_policy('0, 4'd0, '0, 4'd0, 4'h0);
                1: apply_policy('1, 4'd8, '1, 4'd8, 4'hf);
                2: apply_policy(pack_chars("GET"), 4'd3, pack_chars("html"), 4'd4, CHECK_BOTH);
                default:
                begin
                    name = method_names[$urandom_range(0, 5)];
                    mword = pack_chars(name);
                    mlen = 4'(name.len());
                    name = ext_names[$urandom_range(0, 4)];
                    eword = pack_chars(name);
                    elen = 4'(name.len());
                    if ($urandom_range(0, 3) == 0)
                    begin
                        mword = {$urandom, $urandom};
                        mlen = 4'($urandom_range(0, 8));
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        eword = {$urandom, $urandom};
                        elen = 4'($urandom_range(0, 8));
                    end
                    apply_policy(mword, mlen, eword, elen, 4'($urandom_range(0, 15)));
                end
            endcase

            // paths right at the size limit: trailing '/' fits, trailing '/'
            // overflows, a character overflows
            case (phase)
                3: queue_random_request(PATH_LIMIT - 2);
                5: queue_random_request(PATH_LIMIT - 1);
                6: queue_random_request(PATH_LIMIT);
                default: ;
            endcase

            mword = 64'(requests_queued + BYTES_PER_PHASE);
            while (requests_queued < int'(mword))
                queue_random_request(-1);
            wait_until_drained();
        end

        $display("covered %0d request bytes under %0d register settings, %0d long hold-offs",
                 requests_accepted, settings_used, holds_done);
        $display("checked %0d path bytes, %0d verdicts (ok %0d, method %0d, double dot %0d, %s",
                 path_bytes_seen, verdicts_seen, verdict_tally[0], verdict_tally[1],
                 verdict_tally[2], $sformatf("hidden %0d, extension %0d, too long %0d)",
                 verdict_tally[3], verdict_tally[4], verdict_tally[5]));
        if (mismatch_count == 0 && awaited_items.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timed out with %0d items still awaited", awaited_items.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### http_request_path_validator.f
design/hrpv_pkg.sv
design/hrpv_front.sv
design/hrpv_queue.sv
design/hrpv_back.sv
design/http_request_path_validator.sv
bench/tb.sv
